@@ rtl/bpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types, constants, microcode table and helpers of the Bezier point
// evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int MAX_POINTS = 8;
    localparam int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam int COORD_W = 24;
    localparam int T_W     = 17;
    localparam int CNT_W   = 4;
    localparam int PIDX_W  = 3;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = T_W + 1 + DIFF_W;
    localparam int Q_W     = PROD_W - 16;
    localparam int SUM_W   = Q_W + 1;

    localparam logic [T_W-1:0]           T_ONE     = T_W'(65536);
    localparam logic signed [PROD_W-1:0] ROUND_C   = PROD_W'(32768);
    localparam logic signed [SUM_W-1:0]  COORD_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0]  COORD_MIN = -SUM_W'(8388608);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UA_IDLE = 3'd0;
    localparam logic [UPC_W-1:0] UA_READ = 3'd1;
    localparam logic [UPC_W-1:0] UA_DIFF = 3'd2;
    localparam logic [UPC_W-1:0] UA_MUL  = 3'd3;
    localparam logic [UPC_W-1:0] UA_WB   = 3'd4;
    localparam logic [UPC_W-1:0] UA_FRD  = 3'd5;
    localparam logic [UPC_W-1:0] UA_FOUT = 3'd6;

    typedef enum logic [3:0] {
        SQ_NEXT     = 4'b0001,
        SQ_DISPATCH = 4'b0010,
        SQ_LOOP     = 4'b0100,
        SQ_DRAIN    = 4'b1000
    } seq_op_t;

    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic             ld_diff;
        logic             ld_prod;
        logic             wb_en;
        logic             ld_out;
        seq_op_t          op;
        logic [UPC_W-1:0] jmp_a;
        logic [UPC_W-1:0] jmp_b;
    } uword_t;

    typedef struct packed {
        logic           rd_en;
        logic           rd_work;
        logic [AW-1:0]  addr_a;
        logic [AW-1:0]  addr_b;
        logic           ld_diff;
        logic           ld_prod;
        logic           wb_en;
        logic [AW-1:0]  wb_addr;
        logic           st_wr;
        logic [AW-1:0]  st_addr;
        logic [T_W-1:0] t_val;
        logic           ld_out;
    } ctl_t;

    function automatic uword_t ucode(logic [UPC_W-1:0] upc);
        uword_t w;
        w = '{accept: 1'b0, rd_en: 1'b0, ld_diff: 1'b0, ld_prod: 1'b0, wb_en: 1'b0,
              ld_out: 1'b0, op: SQ_NEXT, jmp_a: UA_IDLE, jmp_b: UA_IDLE};
        unique case (upc)
            UA_IDLE: begin
                w.accept = 1'b1;
                w.op     = SQ_DISPATCH;
                w.jmp_a  = UA_READ;
                w.jmp_b  = UA_FRD;
            end
            UA_READ: w.rd_en   = 1'b1;
            UA_DIFF: w.ld_diff = 1'b1;
            UA_MUL:  w.ld_prod = 1'b1;
            UA_WB: begin
                w.wb_en = 1'b1;
                w.op    = SQ_LOOP;
                w.jmp_a = UA_READ;
                w.jmp_b = UA_FRD;
            end
            UA_FRD:  w.rd_en   = 1'b1;
            UA_FOUT: begin
                w.ld_out = 1'b1;
                w.op     = SQ_DRAIN;
                w.jmp_a  = UA_IDLE;
            end
            default: begin
                w.accept = 1'b1;
                w.op     = SQ_DISPATCH;
                w.jmp_a  = UA_READ;
                w.jmp_b  = UA_FRD;
            end
        endcase
        return w;
    endfunction

    // interpolation steps in the first round: points in use minus one
    function automatic logic [AW-1:0] steps_from_count(logic [CNT_W-1:0] pc);
        logic [AW-1:0] s;
        if (pc == '0) begin
            s = '0;
        end else if (32'(pc) > MAX_POINTS) begin
            s = AW'(MAX_POINTS - 1);
        end else begin
            s = AW'(pc - CNT_W'(1));
        end
        return s;
    endfunction

endpackage

@@ rtl/bezier_point_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// De Casteljau evaluation of a Bezier curve over stored control points,
// driven by a microcoded sequencer with one shared lane per coordinate.
// ----------------------------------------------------------------------------
//  channel  | direction | ports
//  s_       | in        | s_valid s_ready s_op s_point_index s_in_x s_in_y s_t_param
//  m_       | out       | m_valid m_ready m_out_x m_out_y
//  cfg_     | in        | cfg_we cfg_wdata (point_count)
//
//  Write item: taken with no result; the next item is taken right after.
//  Evaluate item: no next item is taken until the point is loaded into the
//  result register; each interpolation runs read, subtract, multiply,
//  write-back through the one multiplier of each lane.
//  Reset: point_count returns to 1; control point stores hold garbage until written.
//  Stalls: the result register takes the point; the sequencer holds in its
//  output step only while that register is full and not being drained.
// ----------------------------------------------------------------------------
module bezier_point_evaluator import bpe_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CNT_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic [PIDX_W-1:0]         s_point_index,
    input  logic signed [COORD_W-1:0] s_in_x,
    input  logic signed [COORD_W-1:0] s_in_y,
    input  logic [T_W-1:0]            s_t_param,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_out_x,
    output logic signed [COORD_W-1:0] m_out_y
);

    ctl_t                      ctl;
    logic                      out_free;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic                      m_valid_reg;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;

    assign out_free = !m_valid_reg || m_ready;

    bpe_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_point_index (s_point_index),
        .s_t_param     (s_t_param),
        .out_free      (out_free),
        .ctl           (ctl)
    );

    bpe_lane u_lane_x (
        .aclk    (aclk),
        .ctl     (ctl),
        .st_data (s_in_x),
        .a_val   (ax)
    );

    bpe_lane u_lane_y (
        .aclk    (aclk),
        .ctl     (ctl),
        .st_data (s_in_y),
        .a_val   (ay)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.ld_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_out) begin
            out_x_reg <= ax;
            out_y_reg <= ay;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;

endmodule

@@ rtl/bpe_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_lane
// One coordinate datapath: control point store, work store, subtract,
// multiply and rounded, saturated write-back.
// ----------------------------------------------------------------------------
module bpe_lane import bpe_pkg::*; (
    input  logic                      aclk,
    input  ctl_t                      ctl,
    input  logic signed [COORD_W-1:0] st_data,
    output logic signed [COORD_W-1:0] a_val
);

    logic signed [COORD_W-1:0] ctrl_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] work_mem [MAX_POINTS];

    logic signed [COORD_W-1:0] rd_a_reg;
    logic signed [COORD_W-1:0] rd_b_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [PROD_W-1:0]  rounded;
    logic signed [Q_W-1:0]     quot;
    logic signed [SUM_W-1:0]   sum;
    logic signed [COORD_W-1:0] res;

    always_ff @(posedge aclk) begin
        if (ctl.st_wr) begin
            ctrl_mem[ctl.st_addr] <= st_data;
        end
        if (ctl.wb_en) begin
            work_mem[ctl.wb_addr] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            if (ctl.rd_work) begin
                rd_a_reg <= work_mem[ctl.addr_a];
                rd_b_reg <= work_mem[ctl.addr_b];
            end else begin
                rd_a_reg <= ctrl_mem[ctl.addr_a];
                rd_b_reg <= ctrl_mem[ctl.addr_b];
            end
        end
        if (ctl.ld_diff) begin
            diff_reg <= DIFF_W'(rd_b_reg) - DIFF_W'(rd_a_reg);
        end
        if (ctl.ld_prod) begin
            prod_reg <= PROD_W'($signed({1'b0, ctl.t_val}) * diff_reg);
        end
    end

    always_comb begin
        rounded = prod_reg + ROUND_C;
        quot    = rounded[PROD_W-1:16];
        sum     = SUM_W'(rd_a_reg) + SUM_W'(quot);
        if (sum > COORD_MAX) begin
            res = COORD_MAX[COORD_W-1:0];
        end else if (sum < COORD_MIN) begin
            res = COORD_MIN[COORD_W-1:0];
        end else begin
            res = sum[COORD_W-1:0];
        end
    end

    assign a_val = rd_a_reg;

endmodule

@@ rtl/bpe_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_seq
// Microcode sequencer: step counter over the control word table, round and
// index counters, point count register and parameter register.
// ----------------------------------------------------------------------------
module bpe_seq import bpe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [PIDX_W-1:0] s_point_index,
    input  logic [T_W-1:0]    s_t_param,
    input  logic              out_free,
    output ctl_t              ctl
);

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    steps_reg, steps_next;
    logic             work_reg, work_next;
    logic [T_W-1:0]   t_reg;
    logic [CNT_W-1:0] count_reg;

    uword_t        uw;
    logic          acc;
    logic [AW-1:0] first_steps;
    logic [AW-1:0] idx_inc;

    assign uw          = ucode(upc_reg);
    assign s_ready     = uw.accept;
    assign acc         = s_valid & uw.accept;
    assign first_steps = steps_from_count(count_reg);
    assign idx_inc     = AW'(idx_reg + AW'(1));

    always_comb begin
        upc_next   = upc_reg;
        idx_next   = idx_reg;
        steps_next = steps_reg;
        work_next  = work_reg;
        unique case (uw.op)
            SQ_NEXT: upc_next = UPC_W'(upc_reg + UPC_W'(1));
            SQ_DISPATCH: begin
                if (acc && s_op == OP_EVAL) begin
                    idx_next   = '0;
                    steps_next = first_steps;
                    work_next  = 1'b0;
                    upc_next   = (first_steps == '0) ? uw.jmp_b : uw.jmp_a;
                end
            end
            SQ_LOOP: begin
                if (idx_inc == steps_reg) begin
                    idx_next   = '0;
                    steps_next = AW'(steps_reg - AW'(1));
                    work_next  = 1'b1;
                    upc_next   = (steps_reg == AW'(1)) ? uw.jmp_b : uw.jmp_a;
                end else begin
                    idx_next = idx_inc;
                    upc_next = uw.jmp_a;
                end
            end
            SQ_DRAIN: begin
                if (out_free) begin
                    upc_next = uw.jmp_a;
                end
            end
            default: upc_next = UA_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg   <= UA_IDLE;
            count_reg <= CNT_W'(1);
            idx_reg   <= '0;
            steps_reg <= '0;
            work_reg  <= 1'b0;
        end else begin
            upc_reg   <= upc_next;
            idx_reg   <= idx_next;
            steps_reg <= steps_next;
            work_reg  <= work_next;
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && s_op == OP_EVAL) begin
            t_reg <= (s_t_param > T_ONE) ? T_ONE : s_t_param;
        end
    end

    always_comb begin
        ctl.rd_en   = uw.rd_en;
        ctl.rd_work = work_reg;
        ctl.addr_a  = idx_reg;
        ctl.addr_b  = idx_inc;
        ctl.ld_diff = uw.ld_diff;
        ctl.ld_prod = uw.ld_prod;
        ctl.wb_en   = uw.wb_en;
        ctl.wb_addr = idx_reg;
        ctl.st_wr   = acc && s_op == OP_WRITE && 32'(s_point_index) < MAX_POINTS;
        ctl.st_addr = AW'(s_point_index);
        ctl.t_val   = t_reg;
        ctl.ld_out  = uw.ld_out & out_free;
    end

endmodule

@@ rtl/bpe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_checker
// Port-level checks of the Bezier point evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bpe_checker import bpe_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      s_op,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [COORD_W-1:0] m_out_x,
    input logic signed [COORD_W-1:0] m_out_y
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y))
        else $error("result item changed while stalled");

    a_write_no_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_WRITE |=> s_ready)
        else $error("write item made the block busy");

    a_busy_only_on_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_op == OP_EVAL))
        else $error("block went busy without an evaluate item");

    a_result_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result item appeared while the block was idle");

endmodule

bind bezier_point_evaluator bpe_checker u_bpe_checker (.*);
